### hdl/gbts_pkg.sv
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared constants and codes for the gap buffer text store.
// ----------------------------------------------------------------------------
package gbts_pkg;

  localparam int CAPACITY    = 4096;
  localparam int GAP_RESERVE = 16;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int LEN_W       = ADDR_W + 1;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

endpackage

### hdl/gap_buffer_text_store.sv
// ----------------------------------------------------------------------------
// gap_buffer_text_store
// Editable byte sequence kept as a gap buffer in one dual-port text memory.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | kind, position, data_byte, run_length
//   rsp     | out       | rsp_valid/rsp_stall  | read_byte, length_now, status
//
// clear, edits at the gap and out-of-range requests go from decode straight to the response; reads pass a read state.
// a gap collapse first copies the text bytes behind the gap down to close it.
// an insert away from the gap then shifts the bytes after the position up past a new gap of GAP_RESERVE bytes,
// or writes the byte directly when it lands at the end of the text.
// the copy engine moves one byte a cycle through the memory's read and write ports.
// reset is synchronous; the text memory is not cleared, only the gap pointers and the length.
// a stalled response is held in the output register; the next request is taken meanwhile.
// ----------------------------------------------------------------------------
module gap_buffer_text_store
  import gbts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [1:0]        kind,
  input  logic [LEN_W-1:0]  position,
  input  logic [7:0]        data_byte,
  input  logic [LEN_W-1:0]  run_length,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [7:0]        read_byte,
  output logic [LEN_W-1:0]  length_now,
  output logic [1:0]        status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_COLLAPSE,
    S_SHIFT,
    S_PUT,
    S_READ,
    S_RESP
  } state_t;

  state_t             state;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   gs;
  logic [LEN_W-1:0]   ge;
  kind_t              r_kind;
  logic [LEN_W-1:0]   r_pos;
  logic [7:0]         r_byte;
  logic [LEN_W-1:0]   r_run;
  logic [ADDR_W-1:0]  src;
  logic [ADDR_W-1:0]  dst;
  logic [LEN_W-1:0]   cnt;
  logic               pend;
  logic               move_gap;
  logic [7:0]         res_byte;
  logic [1:0]         res_st;

  logic [7:0]         text_mem [CAPACITY];
  logic [7:0]         rd_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [7:0]         mem_wd;
  logic [ADDR_W-1:0]  mem_ra;

  logic               rsp_free;
  logic               req_take;
  logic [LEN_W-1:0]   gap_sz;
  logic [LEN_W:0]     pos_run;
  logic               fast_ok;
  logic               full;
  logic               ins_bad;
  logic               del_bad;
  logic               rd_bad;
  logic [LEN_W-1:0]   rd_idx;
  logic [LEN_W-1:0]   rd_phys;

  // decode of the held request against the gap pointers
  always_comb begin
    rsp_free = !rsp_valid || !rsp_stall;
    req_stall = !(state == S_IDLE || (state == S_RESP && rsp_free));
    req_take = req_valid && !req_stall;
    gap_sz = ge - gs;
    pos_run = {1'b0, r_pos} + {1'b0, r_run};
    fast_ok = (r_pos == gs) && (ge != gs) &&
              (({1'b0, len} + {1'b0, gap_sz} + (LEN_W+1)'(2)) <= (LEN_W+1)'(CAPACITY));
    full = ({1'b0, len} + (LEN_W+1)'(2 + GAP_RESERVE)) > (LEN_W+1)'(CAPACITY);
    ins_bad = r_pos > len;
    del_bad = pos_run > {1'b0, len};
    rd_bad = (r_pos > len) || (len == '0);
    rd_idx = (r_pos == len) ? r_pos - LEN_W'(1) : r_pos;
    rd_phys = (rd_idx >= gs) ? rd_idx + gap_sz : rd_idx;
  end

  // memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = dst;
    mem_wd = rd_q;
    mem_ra = src;
    unique case (state)
      S_DECODE: begin
        mem_ra = rd_phys[ADDR_W-1:0];
        if (r_kind == KIND_INSERT && !ins_bad && fast_ok) begin
          mem_we = 1'b1;
          mem_wa = gs[ADDR_W-1:0];
          mem_wd = r_byte;
        end
      end
      S_COLLAPSE: begin
        mem_we = pend;
      end
      S_SHIFT: begin
        mem_we = pend;
      end
      S_PUT: begin
        mem_we = 1'b1;
        mem_wa = r_pos[ADDR_W-1:0];
        mem_wd = r_byte;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      text_mem[mem_wa] <= mem_wd;
    end
    rd_q <= text_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len <= '0;
      gs <= '0;
      ge <= LEN_W'(CAPACITY);
      pend <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_RESP && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_take) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_byte <= '0;
          unique case (r_kind)
            KIND_CLEAR: begin
              len <= '0;
              gs <= '0;
              ge <= LEN_W'(CAPACITY);
              res_st <= STATUS_OK;
              state <= S_RESP;
            end
            KIND_INSERT: begin
              if (ins_bad) begin
                res_st <= STATUS_RANGE;
                state <= S_RESP;
              end else if (fast_ok) begin
                gs <= gs + LEN_W'(1);
                len <= len + LEN_W'(1);
                res_st <= STATUS_OK;
                state <= S_RESP;
              end else begin
                res_st <= STATUS_OK;
                state <= S_COLLAPSE;
              end
            end
            KIND_DELETE: begin
              if (del_bad) begin
                res_st <= STATUS_RANGE;
                state <= S_RESP;
              end else if (pos_run[LEN_W-1:0] == gs) begin
                gs <= gs - r_run;
                len <= len - r_run;
                res_st <= STATUS_OK;
                state <= S_RESP;
              end else if (r_pos == gs) begin
                ge <= ge + r_run;
                len <= len - r_run;
                res_st <= STATUS_OK;
                state <= S_RESP;
              end else begin
                res_st <= STATUS_OK;
                state <= S_COLLAPSE;
              end
            end
            KIND_READ: begin
              if (rd_bad) begin
                res_st <= STATUS_RANGE;
                state <= S_RESP;
              end else begin
                res_st <= STATUS_OK;
                state <= S_READ;
              end
            end
          endcase
          src <= ge[ADDR_W-1:0];
          dst <= gs[ADDR_W-1:0];
          cnt <= (gs == ge) ? '0 : len - gs;
          move_gap <= (gs != ge);
          pend <= 1'b0;
        end
        S_COLLAPSE: begin
          if (cnt != '0) begin
            pend <= 1'b1;
            cnt <= cnt - LEN_W'(1);
            src <= src + ADDR_W'(1);
            if (pend) begin
              dst <= dst + ADDR_W'(1);
            end
          end else begin
            pend <= 1'b0;
            if (r_kind == KIND_INSERT) begin
              if (move_gap) begin
                gs <= len;
                ge <= LEN_W'(CAPACITY);
              end
              if (full) begin
                res_st <= STATUS_FULL;
                state <= S_RESP;
              end else if (r_pos == len) begin
                state <= S_PUT;
              end else begin
                src <= ADDR_W'(len - LEN_W'(1));
                dst <= ADDR_W'(len + LEN_W'(GAP_RESERVE));
                cnt <= len - r_pos;
                state <= S_SHIFT;
              end
            end else begin
              gs <= r_pos;
              ge <= pos_run[LEN_W-1:0];
              len <= len - r_run;
              state <= S_RESP;
            end
          end
        end
        S_SHIFT: begin
          if (cnt != '0) begin
            pend <= 1'b1;
            cnt <= cnt - LEN_W'(1);
            src <= src - ADDR_W'(1);
            if (pend) begin
              dst <= dst - ADDR_W'(1);
            end
          end else begin
            pend <= 1'b0;
            state <= S_PUT;
          end
        end
        S_PUT: begin
          gs <= r_pos + LEN_W'(1);
          ge <= r_pos + LEN_W'(1 + GAP_RESERVE);
          len <= len + LEN_W'(1);
          state <= S_RESP;
        end
        S_READ: begin
          res_byte <= rd_q;
          state <= S_RESP;
        end
        S_RESP: begin
          if (rsp_free) begin
            read_byte <= res_byte;
            length_now <= len;
            status <= res_st;
            state <= req_take ? S_DECODE : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (req_take) begin
      r_kind <= kind_t'(kind);
      r_pos <= position;
      r_byte <= data_byte;
      r_run <= run_length;
    end
  end

endmodule

### hdl/gbts_checker.sv
// ----------------------------------------------------------------------------
// gbts_checker
// Port-level checks for the gap buffer text store, bound to the top level.
// ----------------------------------------------------------------------------
module gbts_checker
  import gbts_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input logic [7:0]        read_byte,
  input logic [LEN_W-1:0]  length_now,
  input logic [1:0]        status
);

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(read_byte) &&
      $stable(length_now) && $stable(status))
    else $error("stalled response changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == STATUS_OK || status == STATUS_FULL || status == STATUS_RANGE))
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != STATUS_OK |-> read_byte == 8'd0)
    else $error("failed request returned data");

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> length_now <= LEN_W'(CAPACITY))
    else $error("length beyond capacity");

  // an accepted request makes the block stall requests in the cycle after it is taken
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken without decode cycle");

endmodule

bind gap_buffer_text_store gbts_checker u_gbts_checker (.*);

### tb/gbts_text_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gbts_text_checker
// Watches the request and response channels of the gap buffer text store,
// keeps its own copy of the text, the gap and the length, works out the
// response each accepted request should produce and compares it field by
// field with the responses the block returns, in order.
// ----------------------------------------------------------------------------
module gbts_text_checker
  import gbts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  logic [1:0]        kind,
  input  logic [LEN_W-1:0]  position,
  input  logic [7:0]        data_byte,
  input  logic [LEN_W-1:0]  run_length,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  logic [7:0]        read_byte,
  input  logic [LEN_W-1:0]  length_now,
  input  logic [1:0]        status,
  output int                fail_count,
  output int                pending_count
);

  typedef struct packed {
    logic [7:0]       rd_byte;
    logic [LEN_W-1:0] len;
    logic [1:0]       stat;
  } edit_result_t;

  logic [7:0]   text_mem [CAPACITY];
  int           text_len;
  int           gap_lo;
  int           gap_hi;
  int           rsp_seen;
  edit_result_t result_q [$];

  // push the gap to the end of the store
  function automatic void close_gap();
    if (gap_lo == gap_hi) return;
    if (gap_hi < CAPACITY) begin
      for (int i = 0; i < CAPACITY - gap_hi; i++) text_mem[gap_lo + i] = text_mem[gap_hi + i];
    end
    gap_lo = text_len;
    gap_hi = CAPACITY;
  endfunction

  function automatic logic [1:0] insert_byte(int pos, logic [7:0] b);
    int gap_size;
    gap_size = gap_hi - gap_lo;
    if (pos > text_len) return STATUS_RANGE;
    if (pos == gap_lo && gap_size >= 1 && text_len + 2 + gap_size <= CAPACITY) begin
      text_mem[gap_lo] = b;
      gap_lo++;
      text_len++;
      return STATUS_OK;
    end
    close_gap();
    if (text_len + 2 + GAP_RESERVE > CAPACITY) return STATUS_FULL;
    for (int i = text_len - pos - 1; i >= 0; i--) begin
      text_mem[pos + 1 + GAP_RESERVE + i] = text_mem[pos + i];
    end
    text_mem[pos] = b;
    gap_lo = pos + 1;
    gap_hi = gap_lo + GAP_RESERVE;
    text_len++;
    return STATUS_OK;
  endfunction

  function automatic logic [1:0] delete_run(int pos, int run);
    if (pos + run > text_len) return STATUS_RANGE;
    if (pos + run == gap_lo) begin
      gap_lo -= run;
    end else if (pos == gap_lo) begin
      gap_hi += run;
    end else begin
      close_gap();
      gap_lo = pos;
      gap_hi = pos + run;
    end
    text_len -= run;
    return STATUS_OK;
  endfunction

  function automatic edit_result_t apply_request(logic [1:0] k, int pos, logic [7:0] b, int run);
    edit_result_t r;
    int idx;
    r = '0;
    case (k)
      KIND_CLEAR: begin
        text_len = 0;
        gap_lo = 0;
        gap_hi = CAPACITY;
      end
      KIND_INSERT: r.stat = insert_byte(pos, b);
      KIND_DELETE: r.stat = delete_run(pos, run);
      default: begin
        if (pos > text_len || text_len == 0) begin
          r.stat = STATUS_RANGE;
        end else begin
          idx = (pos == text_len) ? pos - 1 : pos;
          if (idx >= gap_lo) idx += gap_hi - gap_lo;
          if (idx < CAPACITY) r.rd_byte = text_mem[idx];
        end
      end
    endcase
    r.len = LEN_W'(text_len);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    fail_count++;
    $display("%0t response %0d: %s got %0d expected %0d", $time, rsp_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    edit_result_t want;
    if (rst) begin
      text_len = 0;
      gap_lo = 0;
      gap_hi = CAPACITY;
      rsp_seen = 0;
      fail_count = 0;
      result_q.delete();
      pending_count <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (result_q.size() == 0) begin
          report_mismatch("unrequested response, length_now", int'(length_now), -1);
        end else begin
          want = result_q.pop_front();
          if (read_byte !== want.rd_byte) begin
            report_mismatch("read_byte", int'(read_byte), int'(want.rd_byte));
          end
          if (length_now !== want.len) begin
            report_mismatch("length_now", int'(length_now), int'(want.len));
          end
          if (status !== want.stat) begin
            report_mismatch("status", int'(status), int'(want.stat));
          end
        end
        rsp_seen++;
      end
      if (req_valid && !req_stall) begin
        result_q.push_back(apply_request(kind, int'(position), data_byte, int'(run_length)));
      end
      pending_count <= result_q.size();
    end
  end

endmodule

### tb/tb_gap_buffer_text_store.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gap_buffer_text_store
// Drives edit requests into the gap buffer text store: a directed pass over
// the edge cases, then random editing that mimics typing, backspace and
// cursor moves with some malformed requests mixed in.
// Both sides idle at random in changing proportions; a separate checker
// predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_gap_buffer_text_store;
  import gbts_pkg::*;

  localparam int ITEMS_PER_PHASE = 500;
  localparam int WATCHDOG_LIMIT  = 50000;
  localparam int TAIL_CYCLES     = 64;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  logic [1:0]       kind = KIND_CLEAR;
  logic [LEN_W-1:0] position = '0;
  logic [7:0]       data_byte = '0;
  logic [LEN_W-1:0] run_length = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  logic [7:0]       read_byte;
  logic [LEN_W-1:0] length_now;
  logic [1:0]       status;

  int fail_count;
  int results_due;
  int idle_cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int text_len_est = 0;
  int cursor = 0;

  gap_buffer_text_store dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .kind       (kind),
    .position   (position),
    .data_byte  (data_byte),
    .run_length (run_length),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .read_byte  (read_byte),
    .length_now (length_now),
    .status     (status)
  );

  gbts_text_checker text_check (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .kind          (kind),
    .position      (position),
    .data_byte     (data_byte),
    .run_length    (run_length),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .read_byte     (read_byte),
    .length_now    (length_now),
    .status        (status),
    .fail_count    (fail_count),
    .pending_count (results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_gap_buffer_text_store failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(kind_t k, int pos, int data, int run);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid  = 1'b1;
    kind       = k;
    position   = LEN_W'(pos);
    data_byte  = 8'(data);
    run_length = LEN_W'(run);
    do @(posedge clk); while (req_stall);
    case (k)
      KIND_CLEAR: text_len_est = 0;
      KIND_INSERT: if (pos <= text_len_est && text_len_est + 2 + GAP_RESERVE <= CAPACITY) begin
        text_len_est++;
      end
      KIND_DELETE: if (pos + run <= text_len_est) text_len_est -= run;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic directed_edits();
    send_request(KIND_CLEAR, 8191, 8'hFF, 8191);
    send_request(KIND_READ, 0, 0, 0);
    send_request(KIND_INSERT, 1, 8'h11, 0);
    send_request(KIND_DELETE, 0, 0, 0);
    send_request(KIND_INSERT, 0, 8'h00, 8191);
    send_request(KIND_INSERT, 1, 8'hFF, 0);
    send_request(KIND_INSERT, 2, 8'h5A, 0);
    send_request(KIND_INSERT, 0, 8'hA5, 0);
    send_request(KIND_READ, 4, 0, 0);
    send_request(KIND_READ, 0, 0, 0);
    send_request(KIND_READ, 5, 0, 0);
    send_request(KIND_DELETE, 1, 0, 1);
    send_request(KIND_DELETE, 0, 0, 1);
    send_request(KIND_DELETE, 1, 0, 0);
    send_request(KIND_INSERT, 1, 8'h3C, 0);
    send_request(KIND_DELETE, 1, 0, 1);
    send_request(KIND_DELETE, 0, 0, 8191);
    send_request(KIND_DELETE, 8191, 0, 0);
    send_request(KIND_INSERT, 8191, 8'h77, 0);
    send_request(KIND_READ, 8191, 0, 0);
    send_request(KIND_READ, text_len_est, 0, 0);
    send_request(KIND_CLEAR, 0, 0, 0);
    send_request(KIND_READ, 0, 0, 0);
    cursor = 0;
  endtask

  task automatic random_edit();
    int pick;
    int pos;
    int run;
    int len_before;
    pick = $urandom_range(0, 99);
    if (cursor > text_len_est) cursor = text_len_est;
    len_before = text_len_est;
    if (pick < 40) begin
      // typing at the cursor, sometimes after a jump
      if (pick >= 30) cursor = $urandom_range(0, text_len_est);
      send_request(KIND_INSERT, cursor, $urandom_range(0, 255), $urandom_range(0, 8191));
      if (text_len_est > len_before) cursor++;
    end else if (pick < 48) begin
      if (cursor > 0) begin
        send_request(KIND_DELETE, cursor - 1, $urandom_range(0, 255), 1);
        cursor--;
      end else begin
        send_request(KIND_DELETE, 0, $urandom_range(0, 255), 0);
      end
    end else if (pick < 54) begin
      run = $urandom_range(0, (text_len_est - cursor < 3) ? text_len_est - cursor : 3);
      send_request(KIND_DELETE, cursor, $urandom_range(0, 255), run);
    end else if (pick < 62) begin
      pos = $urandom_range(0, text_len_est);
      run = (text_len_est > 100 || text_len_est - pos < 8) ? text_len_est - pos : 8;
      send_request(KIND_DELETE, pos, $urandom_range(0, 255), $urandom_range(0, run));
    end else if (pick < 84) begin
      send_request(KIND_READ, $urandom_range(0, text_len_est), $urandom_range(0, 255),
                   $urandom_range(0, 8191));
    end else if (pick < 96) begin
      send_request(kind_t'($urandom_range(1, 3)), $urandom_range(0, 8191),
                   $urandom_range(0, 255), $urandom_range(0, 8191));
    end else begin
      send_request(KIND_CLEAR, $urandom_range(0, 8191), $urandom_range(0, 255),
                   $urandom_range(0, 8191));
      cursor = 0;
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;

    tx_idle_pct = 20;
    rx_idle_pct = 68;
    directed_edits();
    repeat (ITEMS_PER_PHASE) random_edit();

    tx_idle_pct = 68;
    rx_idle_pct = 20;
    repeat (ITEMS_PER_PHASE) random_edit();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (ITEMS_PER_PHASE) random_edit();

    req_valid = 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_gap_buffer_text_store passed");
    end else begin
      $display("tb_gap_buffer_text_store failed");
    end
    $finish;
  end

endmodule
